// ----- rtl/core/nearest_point_on_segments_unit_defines.svh -----
// Assertion macros for the nearest point on segments unit.
// Included by the checker module; depends on nothing else.
`ifndef NEAREST_POINT_ON_SEGMENTS_UNIT_DEFINES_SVH
`define NEAREST_POINT_ON_SEGMENTS_UNIT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define NPS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal must be low while reset is applied.
`define NPS_ASSERT_RST(label, clk, rst_n, sig, msg) \
  label: assert property (@(posedge clk) !rst_n |-> !sig) else $error(msg);

`endif

// ----- rtl/core/nps_pkg.sv -----
// Shared types and constants for the nearest point on segments unit.
// No dependencies.
package nps_pkg;

  typedef enum logic {
    MODE_QUERY = 1'b0,
    MODE_SEG   = 1'b1
  } mode_e;

  // How the front end has classified the projection parameter t.
  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_ONE  = 2'd1,
    CLS_DIV  = 2'd2
  } cls_e;

endpackage

// ----- rtl/core/nearest_point_on_segments_unit.sv -----
// Nearest point on segments unit. The item kind (query or candidate) travels in
// tuser. Every item passes a two-stage front end, which takes no new item while
// its first stage holds one, into a one-entry queue register. In the back end a
// candidate goes through ST_MUL, ST_FOOT, ST_DIST and ST_CMP; when t must be
// divided out, its bit-serial restoring divider runs in ST_DIV first. A query
// item only resets the running best. An item flagged last then hands its result
// to the output register in ST_OUT, waiting there while an earlier result is still held.
// Depends on nps_pkg, nps_front and nps_back.
module nearest_point_on_segments_unit
  import nps_pkg::*;
#(
  parameter int COORD_BITS   = 24,
  parameter int NODE_ID_BITS = 16,
  parameter int T_FRAC_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: ax, ay, bx, by, target_node (lowest first), zero padded
  input  logic [((4*COORD_BITS+NODE_ID_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser: mode
  input  logic s_axis_tuser,
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tdata: closest_x, closest_y, node_id, best_distance, found (lowest first)
  output logic [((4*COORD_BITS+NODE_ID_BITS+3+7)/8)*8-1:0] m_axis_tdata
);
  localparam int CW = COORD_BITS;
  localparam int NW = NODE_ID_BITS;
  localparam int OW = 4*CW + NW + 3;
  localparam int OB = ((OW + 7)/8)*8;

  logic                 q_valid, q_ready, q_mode, q_last;
  logic signed [CW-1:0] q_ax, q_ay;
  logic signed [CW:0]   q_abx, q_aby;
  logic [2*CW+2:0]      q_len, q_dot;
  logic [1:0]           q_cls;
  logic [NW-1:0]        q_node, node_o;
  logic signed [CW-1:0] qx_q, qy_q;
  logic [CW-1:0]        cx, cy;
  logic [2*CW+1:0]      best_d;
  logic                 found;

  nps_front #(.CW(CW), .NW(NW)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .mode_i(s_axis_tuser),
    .ax_i(s_axis_tdata[0 +: CW]),      .ay_i(s_axis_tdata[CW +: CW]),
    .bx_i(s_axis_tdata[2*CW +: CW]),   .by_i(s_axis_tdata[3*CW +: CW]),
    .node_i(s_axis_tdata[4*CW +: NW]), .last_i(s_axis_tlast),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_mode_o(q_mode), .q_last_o(q_last),
    .q_ax_o(q_ax), .q_ay_o(q_ay), .q_abx_o(q_abx), .q_aby_o(q_aby),
    .q_len_o(q_len), .q_dot_o(q_dot), .q_cls_o(q_cls), .q_node_o(q_node)
  );

  // The back end keeps its own copy of the query, loaded as query items pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qx_q <= '0;
      qy_q <= '0;
    end else if (q_valid && q_ready && q_mode == MODE_QUERY) begin
      qx_q <= q_ax;
      qy_q <= q_ay;
    end
  end

  nps_back #(.CW(CW), .NW(NW), .TW(T_FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_mode_i(q_mode), .q_last_i(q_last),
    .q_ax_i(q_ax), .q_ay_i(q_ay), .q_abx_i(q_abx), .q_aby_i(q_aby),
    .q_len_i(q_len), .q_dot_i(q_dot), .q_cls_i(q_cls), .q_node_i(q_node),
    .qx_i(qx_q), .qy_i(qy_q),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .cx_o(cx), .cy_o(cy), .node_o(node_o), .dist_o(best_d), .found_o(found)
  );

  assign m_axis_tdata = OB'({found, best_d, node_o, cy, cx});
endmodule

// ----- rtl/core/nps_front.sv -----
// Front end: accepts items, forms the exact segment terms and the clamp class.
// Depends on nps_pkg.
module nps_front
  import nps_pkg::*;
#(
  parameter int CW = 24,
  parameter int NW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 mode_i,
  input  logic signed [CW-1:0] ax_i,
  input  logic signed [CW-1:0] ay_i,
  input  logic signed [CW-1:0] bx_i,
  input  logic signed [CW-1:0] by_i,
  input  logic [NW-1:0]        node_i,
  input  logic                 last_i,
  output logic                 q_valid_o,
  input  logic                 q_ready_i,
  output logic                 q_mode_o,
  output logic                 q_last_o,
  output logic signed [CW-1:0] q_ax_o,
  output logic signed [CW-1:0] q_ay_o,
  output logic signed [CW:0]   q_abx_o,
  output logic signed [CW:0]   q_aby_o,
  output logic [2*CW+2:0]      q_len_o,
  output logic [2*CW+2:0]      q_dot_o,
  output logic [1:0]           q_cls_o,
  output logic [NW-1:0]        q_node_o
);
  localparam int LW = 2*CW + 3;

  // Two stages: accept+difference/product, then sum/classify.
  logic                 s1_v_q, s2_v_q;
  logic                 s1_mode_q, s1_last_q;
  logic signed [CW-1:0] s1_ax_q, s1_ay_q;
  logic signed [CW:0]   s1_abx_q, s1_aby_q;
  logic signed [LW-1:0] s1_pxx_q, s1_pyy_q, s1_pxd_q, s1_pyd_q;
  logic [NW-1:0]        s1_node_q;
  logic signed [CW-1:0] qx_q, qy_q;
  logic signed [CW:0]   abx, aby, apx, apy;
  logic signed [LW:0]   dot_s;
  logic [LW-1:0]        len_s;
  logic                 adv;

  assign adv        = !q_valid_o || q_ready_i;
  assign in_ready_o = !s1_v_q;
  assign abx = {bx_i[CW-1], bx_i} - {ax_i[CW-1], ax_i};
  assign aby = {by_i[CW-1], by_i} - {ay_i[CW-1], ay_i};
  assign apx = {qx_q[CW-1], qx_q} - {ax_i[CW-1], ax_i};
  assign apy = {qy_q[CW-1], qy_q} - {ay_i[CW-1], ay_i};
  assign len_s = LW'(s1_pxx_q + s1_pyy_q);
  assign dot_s = (LW+1)'(s1_pxd_q) + (LW+1)'(s1_pyd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      qx_q   <= '0;
      qy_q   <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        s1_v_q    <= 1'b1;
        s1_mode_q <= mode_i;
        s1_last_q <= last_i;
        s1_ax_q   <= ax_i;
        s1_ay_q   <= ay_i;
        s1_abx_q  <= abx;
        s1_aby_q  <= aby;
        s1_pxx_q  <= LW'(abx * abx);
        s1_pyy_q  <= LW'(aby * aby);
        s1_pxd_q  <= LW'(apx * abx);
        s1_pyd_q  <= LW'(apy * aby);
        s1_node_q <= node_i;
        if (mode_i == MODE_QUERY) begin
          qx_q <= ax_i;
          qy_q <= ay_i;
        end
      end else if (s1_v_q && adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_v_q && adv) begin
        s2_v_q   <= 1'b1;
        q_mode_o <= s1_mode_q;
        q_last_o <= s1_last_q;
        q_ax_o   <= s1_ax_q;
        q_ay_o   <= s1_ay_q;
        q_abx_o  <= s1_abx_q;
        q_aby_o  <= s1_aby_q;
        q_len_o  <= len_s;
        q_dot_o  <= LW'(dot_s);
        q_node_o <= s1_node_q;
        if (len_s == '0 || dot_s <= 0)                q_cls_o <= CLS_ZERO;
        else if ((LW+1)'(dot_s) >= {1'b0, len_s})     q_cls_o <= CLS_ONE;
        else                                          q_cls_o <= CLS_DIV;
      end else if (q_ready_i) begin
        s2_v_q <= 1'b0;
      end
    end
  end
  assign q_valid_o = s2_v_q;
endmodule

// ----- rtl/core/nps_back.sv -----
// Back end: restoring divide for t, foot point, distance and running best.
// Depends on nps_pkg.
module nps_back
  import nps_pkg::*;
#(
  parameter int CW = 24,
  parameter int NW = 16,
  parameter int TW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_ready_o,
  input  logic                 q_mode_i,
  input  logic                 q_last_i,
  input  logic signed [CW-1:0] q_ax_i,
  input  logic signed [CW-1:0] q_ay_i,
  input  logic signed [CW:0]   q_abx_i,
  input  logic signed [CW:0]   q_aby_i,
  input  logic [2*CW+2:0]      q_len_i,
  input  logic [2*CW+2:0]      q_dot_i,
  input  logic [1:0]           q_cls_i,
  input  logic [NW-1:0]        q_node_i,
  input  logic signed [CW-1:0] qx_i,
  input  logic signed [CW-1:0] qy_i,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output logic [CW-1:0]        cx_o,
  output logic [CW-1:0]        cy_o,
  output logic [NW-1:0]        node_o,
  output logic [2*CW+1:0]      dist_o,
  output logic                 found_o
);
  localparam int LW = 2*CW + 3;
  localparam int DW = 2*CW + 2;
  localparam int PW = CW + TW + 2;
  localparam int CNTW = $clog2(TW + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_MUL, ST_FOOT, ST_DIST, ST_CMP, ST_OUT
  } state_e;

  state_e                state_q;
  logic [CNTW-1:0]       cnt_q;
  logic [LW:0]           r_q;
  logic [LW-1:0]         len_q;
  logic [TW:0]           t_q;
  logic                  last_q;
  logic signed [CW-1:0]  ax_q, ay_q;
  logic signed [CW:0]    abx_q, aby_q;
  logic signed [PW-1:0]  mx_q, my_q;
  logic signed [CW+1:0]  ex_q, ey_q;
  logic signed [CW-1:0]  px_q, py_q;
  logic [DW-1:0]         d_q;
  logic [NW-1:0]         nd_q;
  logic [DW-1:0]         best_dist_q;
  logic [CW-1:0]         best_x_q, best_y_q;
  logic [NW-1:0]         best_node_q;
  logic                  seen_q;
  logic [LW:0]           r_sh;
  logic signed [PW-1:0]  rx, ry;
  logic signed [CW+1:0]  fx, fy;

  assign q_ready_o = (state_q == ST_IDLE);
  assign r_sh = {r_q[LW-1:0], 1'b0};
  // Round to nearest, ties upward: arithmetic shift floors after the half add.
  assign rx = (mx_q + PW'(1 << (TW-1))) >>> TW;
  assign ry = (my_q + PW'(1 << (TW-1))) >>> TW;
  assign fx = (CW+2)'(ax_q) + (CW+2)'(rx);
  assign fy = (CW+2)'(ay_q) + (CW+2)'(ry);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      m_valid_o   <= 1'b0;
      best_dist_q <= '1;
      best_x_q    <= '0;
      best_y_q    <= '0;
      best_node_q <= '0;
      seen_q      <= 1'b0;
      cnt_q       <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            last_q <= q_last_i;
            ax_q   <= q_ax_i;
            ay_q   <= q_ay_i;
            abx_q  <= q_abx_i;
            aby_q  <= q_aby_i;
            nd_q   <= q_node_i;
            len_q  <= q_len_i;
            r_q    <= {1'b0, q_dot_i};
            cnt_q  <= '0;
            t_q    <= (q_cls_i == CLS_ONE) ? (TW+1)'(1 << TW) : '0;
            if (q_mode_i == MODE_QUERY) begin
              best_dist_q <= '1;
              best_x_q    <= '0;
              best_y_q    <= '0;
              best_node_q <= '0;
              seen_q      <= 1'b0;
              state_q     <= q_last_i ? ST_OUT : ST_IDLE;
            end else begin
              state_q <= (q_cls_i == CLS_DIV) ? ST_DIV : ST_MUL;
            end
          end
        end
        ST_DIV: begin
          if (r_sh >= {1'b0, len_q}) begin
            r_q <= r_sh - {1'b0, len_q};
            t_q <= {t_q[TW-1:0], 1'b1};
          end else begin
            r_q <= r_sh;
            t_q <= {t_q[TW-1:0], 1'b0};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNTW'(TW - 1)) state_q <= ST_MUL;
        end
        ST_MUL: begin
          mx_q    <= PW'($signed({1'b0, t_q}) * abx_q);
          my_q    <= PW'($signed({1'b0, t_q}) * aby_q);
          state_q <= ST_FOOT;
        end
        ST_FOOT: begin
          px_q    <= CW'(fx);
          py_q    <= CW'(fy);
          ex_q    <= fx - (CW+2)'(qx_i);
          ey_q    <= fy - (CW+2)'(qy_i);
          state_q <= ST_DIST;
        end
        ST_DIST: begin
          d_q     <= DW'(ex_q * ex_q) + DW'(ey_q * ey_q);
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (d_q < best_dist_q) begin
            best_dist_q <= d_q;
            best_x_q    <= px_q;
            best_y_q    <= py_q;
            best_node_q <= nd_q;
          end
          seen_q  <= 1'b1;
          state_q <= last_q ? ST_OUT : ST_IDLE;
        end
        ST_OUT: begin
          if (!m_valid_o || m_ready_i) begin
            m_valid_o <= 1'b1;
            cx_o      <= seen_q ? best_x_q : '0;
            cy_o      <= seen_q ? best_y_q : '0;
            node_o    <= seen_q ? best_node_q : '1;
            dist_o    <= best_dist_q;
            found_o   <= seen_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (m_valid_o && m_ready_i && !(state_q == ST_OUT)) m_valid_o <= 1'b0;
    end
  end
endmodule

// ----- rtl/core/nps_checker.sv -----
// Port-level checker for the nearest point on segments unit, bound to the top.
// Depends on the assertion macro header.
`include "nearest_point_on_segments_unit_defines.svh"
module nps_checker #(
  parameter int OB = 128
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          m_axis_tvalid,
  input logic          m_axis_tready,
  input logic [OB-1:0] m_axis_tdata
);
  logic stalled;

  assign stalled = m_axis_tvalid && !m_axis_tready;

  `NPS_ASSERT_RST(a_no_out_in_reset, clk_i, rst_ni, m_axis_tvalid, "result during reset")
  `NPS_ASSERT(a_hold, clk_i, rst_ni, stalled |=> m_axis_tvalid && $stable(m_axis_tdata), "held")
  `NPS_ASSERT(a_known, clk_i, rst_ni, m_axis_tvalid |-> !$isunknown(m_axis_tdata), "unknown")
endmodule

bind nearest_point_on_segments_unit nps_checker #(.OB($bits(m_axis_tdata))) u_checker (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for nearest_point_on_segments_unit.
// Drives query and candidate streams, predicts the nearest point in a
// scoreboard class and compares every result transfer; depends on nps_pkg.
`timescale 1ns / 100ps

module tb_top;
  import nps_pkg::*;

  localparam int CB = 24;
  localparam int NB = 16;
  localparam int TF = 16;
  localparam int DB = 2 * CB + 2;
  localparam int IW = ((4 * CB + NB + 7) / 8) * 8;
  localparam int OW = ((4 * CB + NB + 3 + 7) / 8) * 8;
  localparam int N_ITEMS = 450;

  typedef struct {
    mode_e            mode;
    logic signed [CB-1:0] ax, ay, bx, by;
    logic [NB-1:0]    node;
    logic             last;
  } seg_item_t;

  typedef struct {
    logic signed [CB-1:0] cx, cy;
    logic [NB-1:0]    node;
    logic [DB-1:0]    sqd;
    logic             found;
  } nearest_t;

  class nearest_scoreboard;
    longint qx, qy, bx, by;
    logic [DB-1:0] bdist;
    logic [NB-1:0] bnode;
    bit seen;
    nearest_t nearest_q[$];
    int mismatches;

    function new();
      qx = 0;
      qy = 0;
      clear_best();
    endfunction

    function void clear_best();
      bdist = '1;
      bx = 0;
      by = 0;
      bnode = '0;
      seen = 0;
    endfunction

    function void note_input(seg_item_t it);
      longint abx, aby, apx, apy, len, dot, t, px, py, sq_d;
      logic [DB+TF+31:0] num;
      nearest_t r;
      if (it.mode == MODE_QUERY) begin
        qx = it.ax;
        qy = it.ay;
        clear_best();
      end else begin
        abx = longint'(it.bx) - longint'(it.ax);
        aby = longint'(it.by) - longint'(it.ay);
        apx = qx - it.ax;
        apy = qy - it.ay;
        len = abx * abx + aby * aby;
        dot = apx * abx + apy * aby;
        t = 0;
        if (len != 0 && dot > 0) begin
          if (dot >= len) begin
            t = longint'(1) << TF;
          end else begin
            num = DB'(dot);
            num = num << TF;
            t = longint'(num / len);
          end
        end
        // Rounded to nearest, ties upward: arithmetic shift floors.
        px = longint'(it.ax) + ((t * abx + (longint'(1) << (TF - 1))) >>> TF);
        py = longint'(it.ay) + ((t * aby + (longint'(1) << (TF - 1))) >>> TF);
        sq_d = (px - qx) * (px - qx) + (py - qy) * (py - qy);
        if (DB'(sq_d) < bdist) begin
          bdist = DB'(sq_d);
          bx = px;
          by = py;
          bnode = it.node;
        end
        seen = 1;
      end
      if (it.last) begin
        if (seen) begin
          r.cx = CB'(bx);
          r.cy = CB'(by);
          r.node = bnode;
          r.sqd = bdist;
          r.found = 1'b1;
        end else begin
          r.cx = '0;
          r.cy = '0;
          r.node = '1;
          r.sqd = '1;
          r.found = 1'b0;
        end
        nearest_q = {nearest_q, r};
      end
    endfunction

    function void check_result(nearest_t got);
      nearest_t exp_r;
      if (nearest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: x=%0d y=%0d node=%0d", got.cx, got.cy,
                   got.node);
        return;
      end
      exp_r = nearest_q.pop_front();
      if (got.cx !== exp_r.cx || got.cy !== exp_r.cy || got.node !== exp_r.node ||
          got.sqd !== exp_r.sqd || got.found !== exp_r.found) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp x=%0d y=%0d node=%0d d=%0d f=%0b, got x=%0d y=%0d node=%0d d=%0d f=%0b",
                   exp_r.cx, exp_r.cy, exp_r.node, exp_r.sqd, exp_r.found,
                   got.cx, got.cy, got.node, got.sqd, got.found);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, s_axis_tlast, s_axis_tuser;
  logic [IW-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [OW-1:0] m_axis_tdata;

  nearest_point_on_segments_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  nearest_scoreboard sb = new();
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int items_sent;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("[nearest_point_on_segments_unit] ERROR");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off to back the block up.
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        hold_cnt = 300;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    nearest_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.cx = m_axis_tdata[CB-1:0];
      got.cy = m_axis_tdata[2*CB-1:CB];
      got.node = m_axis_tdata[2*CB+NB-1:2*CB];
      got.sqd = m_axis_tdata[2*CB+NB+DB-1:2*CB+NB];
      got.found = m_axis_tdata[2*CB+NB+DB];
      sb.check_result(got);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(seg_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IW'({it.node, it.by, it.bx, it.ay, it.ax});
    s_axis_tuser <= it.mode;
    s_axis_tlast <= it.last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_query(longint x, longint y, logic last);
    seg_item_t it;
    it.mode = MODE_QUERY;
    it.ax = CB'(x);
    it.ay = CB'(y);
    it.bx = CB'($urandom);
    it.by = CB'($urandom);
    it.node = NB'($urandom);
    it.last = last;
    send_item(it);
  endtask

  task automatic send_seg(longint ax, longint ay, longint bx, longint by, int node,
                          logic last);
    seg_item_t it;
    it.mode = MODE_SEG;
    it.ax = CB'(ax);
    it.ay = CB'(ay);
    it.bx = CB'(bx);
    it.by = CB'(by);
    it.node = NB'(node);
    it.last = last;
    send_item(it);
  endtask

  function automatic longint rand_coord(bit full, longint centre);
    if (full) return longint'($signed(CB'($urandom)));
    return centre + $signed($urandom_range(8191)) - 4096;
  endfunction

  localparam longint CMAX = (longint'(1) << (CB - 1)) - 1;
  localparam longint CMIN = -(longint'(1) << (CB - 1));

  initial begin
    longint qx, qy, ax, ay;
    int n_cand;
    bit full;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    items_sent = 0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Candidate straight after reset uses the reset query at the origin.
    send_seg(100, 200, 100, 200, 7, 1'b1);
    // Last on a query item: nothing seen yet.
    send_query(5, 5, 1'b1);
    send_query(0, 0, 1'b0);
    // Zero length segment, clamp at the start, interior projections.
    send_seg(4096, 0, 4096, 0, 1, 1'b0);
    send_seg(8192, 100, 20000, 100, 2, 1'b0);
    send_seg(-5000, -3000, -100, -7000, 3, 1'b0);
    send_seg(-3000, 1000, 3000, 1001, 4, 1'b1);
    // Ties keep the first candidate.
    send_query(0, 0, 1'b0);
    send_seg(1000, 0, 1000, 0, 16'h1111, 1'b0);
    send_seg(0, 1000, 0, 1000, 16'h2222, 1'b0);
    send_seg(-1000, 0, -1000, 0, 16'hffff, 1'b1);
    // Field extremes.
    send_query(CMAX, CMIN, 1'b0);
    send_seg(CMIN, CMAX, CMAX, CMIN, 16'h0000, 1'b0);
    send_seg(CMIN, CMIN, CMAX, CMAX, 16'hffff, 1'b0);
    send_seg(CMAX, CMIN, CMAX, CMIN, 16'h8000, 1'b1);
    send_query(CMIN, CMAX, 1'b0);
    send_seg(CMAX, CMAX, CMIN, CMIN, 16'h5a5a, 1'b1);
    // A candidate after a result without a fresh query.
    send_seg(0, 0, CMAX, 0, 9, 1'b1);

    hold_req = 1;
    while (items_sent < N_ITEMS) begin
      case ((items_sent * 4) / N_ITEMS)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      full = ($urandom_range(4) == 0);
      qx = rand_coord(full, $signed($urandom_range(65535)) - 32768);
      qy = rand_coord(full, $signed($urandom_range(65535)) - 32768);
      // Mostly well-formed queries; occasionally an empty or headless one.
      if ($urandom_range(9) != 0) send_query(qx, qy, $urandom_range(19) == 0);
      n_cand = $urandom_range(6);
      for (int i = 0; i < n_cand; i++) begin
        ax = rand_coord(full, qx);
        ay = rand_coord(full, qy);
        if ($urandom_range(3) == 0)
          send_seg(ax, ay, ax, ay, $urandom, i == n_cand - 1);
        else
          send_seg(ax, ay, rand_coord(full, qx), rand_coord(full, qy), $urandom,
                   i == n_cand - 1 || $urandom_range(15) == 0);
      end
    end
    s_axis_tvalid <= 1'b0;
    recv_stall_pct = 0;
    while (sb.nearest_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("[nearest_point_on_segments_unit] OK");
    else
      $display("[nearest_point_on_segments_unit] ERROR");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/nps_pkg.sv
rtl/core/nps_front.sv
rtl/core/nps_back.sv
rtl/core/nearest_point_on_segments_unit.sv
rtl/core/nps_checker.sv
tb/tb_top.sv
